FILE: rtl/tmsd_pkg.sv
// Shared constants and types for the trait mean and spread block.
`default_nettype none
package tmsd_pkg;
    localparam int MAX_RECORDS = 256;
    localparam int TRAIT_BITS  = 16;
    localparam int NUM_TRAITS  = 3;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int SUM_W  = TRAIT_BITS + CNT_W;
    localparam int VAR_W  = 2 * TRAIT_BITS;
    localparam int SQ_W   = VAR_W + CNT_W;
    localparam int REC_W  = NUM_TRAITS * TRAIT_BITS;
    localparam int STEP_W = $clog2(SQ_W + 1);
    localparam int SR_W   = TRAIT_BITS + 3;

    typedef logic [TRAIT_BITS-1:0] trait_t;
endpackage
`default_nettype wire

FILE: rtl/tmsd_if.sv
// Record and result channels with valid/ready handshake.
`default_nettype none
interface tmsd_rec_if;
    import tmsd_pkg::*;
    logic   valid;
    logic   ready;
    logic   has_record;
    trait_t limb;
    trait_t mass;
    trait_t scale;
    logic   last_record;
    modport source (output valid, has_record, limb, mass, scale,
                    last_record, input ready);
    modport sink (input valid, has_record, limb, mass, scale,
                  last_record, output ready);
endinterface

interface tmsd_res_if;
    import tmsd_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] record_count;
    trait_t           mean_limb;
    trait_t           mean_mass;
    trait_t           mean_scale;
    trait_t           spread_limb;
    trait_t           spread_mass;
    trait_t           spread_scale;
    logic             overflowed;
    modport source (output valid, record_count, mean_limb, mean_mass, mean_scale,
                    spread_limb, spread_mass, spread_scale, overflowed, input ready);
    modport sink (input valid, record_count, mean_limb, mean_mass, mean_scale,
                  spread_limb, spread_mass, spread_scale, overflowed, output ready);
endinterface
`default_nettype wire

FILE: rtl/trait_mean_and_std_dev.sv
// Top level: record store, running sums, serial divide, squared-deviation pass, serial root.
// Loading takes one record request per cycle while idle; the store write and sums update in that cycle.
// After the closing request each trait runs a bit-serial divide for the mean, a pass over the store,
// a second divide and a 2-bit-per-cycle root. An empty set skips these and goes straight to done.
// The result waits in an output register.
// Reset clears count, sums, drop flag and control; the record store needs no clearing.
`default_nettype none
module trait_mean_and_std_dev (
    input wire logic clk,
    input wire logic rst_n,
    tmsd_rec_if.sink   records,
    tmsd_res_if.source stats
);
    import tmsd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MSTART = 3'd1;
    localparam logic [2:0] S_MDIV   = 3'd2;
    localparam logic [2:0] S_PASS   = 3'd3;
    localparam logic [2:0] S_VDIV   = 3'd4;
    localparam logic [2:0] S_SQRT   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        state_reg;
    logic [1:0]        t_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  sum_reg [NUM_TRAITS];
    logic              drop_reg;
    trait_t            mean_reg [NUM_TRAITS];
    trait_t            spread_reg [NUM_TRAITS];
    logic [STEP_W-1:0] step_reg;
    logic [SQ_W-1:0]   dq_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [VAR_W-1:0]  rad_reg;
    logic [SR_W-1:0]   srem_reg;
    trait_t            root_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              issue_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    trait_t            d_reg;
    logic [VAR_W-1:0]  sq_reg;
    logic [SQ_W-1:0]   acc_reg;
    logic              out_valid_reg;

    logic              accept;
    logic              room;
    logic              we;
    logic [REC_W-1:0]  wdata;
    logic [REC_W-1:0]  rdata;
    trait_t            x_sel;
    trait_t            m_sel;
    logic [CNT_W:0]    trial_d;
    logic              ge_d;
    logic [CNT_W:0]    diff_d;
    logic [SR_W-1:0]   cur_s;
    logic [SR_W-1:0]   trial_s;
    logic              ge_s;
    logic [ADDR_W-1:0] last_addr;

    assign accept  = records.valid && records.ready;
    assign records.ready = (state_reg == S_IDLE);
    assign room    = (cnt_reg < CNT_W'(MAX_RECORDS));
    assign we      = accept && records.has_record && room;
    assign wdata   = {records.scale, records.mass, records.limb};
    assign last_addr = ADDR_W'(cnt_reg - CNT_W'(1));

    tmsd_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (ADDR_W'(cnt_reg)),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        x_sel   = rdata[t_reg*TRAIT_BITS +: TRAIT_BITS];
        m_sel   = mean_reg[t_reg];
        trial_d = {rem_reg, dq_reg[SQ_W-1]};
        ge_d    = (trial_d >= {1'b0, cnt_reg});
        diff_d  = trial_d - {1'b0, cnt_reg};
        cur_s   = {srem_reg[SR_W-3:0], rad_reg[VAR_W-1 -: 2]};
        trial_s = SR_W'({root_reg, 2'b01});
        ge_s    = (cur_s >= trial_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            step_reg      <= '0;
            issue_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TRAITS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || stats.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stats.valid && stats.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            v1_reg <= issue_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (we)
                        begin
                            cnt_reg    <= cnt_reg + CNT_W'(1);
                            sum_reg[0] <= sum_reg[0] + SUM_W'(records.limb);
                            sum_reg[1] <= sum_reg[1] + SUM_W'(records.mass);
                            sum_reg[2] <= sum_reg[2] + SUM_W'(records.scale);
                        end
                        else if (records.has_record)
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (records.last_record)
                        begin
                            t_reg <= '0;
                            if (cnt_reg == '0 && !we)
                            begin
                                for (int i = 0; i < NUM_TRAITS; i++)
                                begin
                                    mean_reg[i]   <= '0;
                                    spread_reg[i] <= '0;
                                end
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_MSTART;
                            end
                        end
                    end
                end
                S_MSTART:
                begin
                    dq_reg    <= SQ_W'(sum_reg[t_reg]);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_MDIV;
                end
                S_MDIV:
                begin
                    if (step_reg == STEP_W'(SQ_W))
                    begin
                        mean_reg[t_reg] <= dq_reg[TRAIT_BITS-1:0];
                        addr_reg        <= '0;
                        issue_reg       <= 1'b1;
                        acc_reg         <= '0;
                        state_reg       <= S_PASS;
                    end
                    else
                    begin
                        rem_reg  <= ge_d ? diff_d[CNT_W-1:0] : trial_d[CNT_W-1:0];
                        dq_reg   <= {dq_reg[SQ_W-2:0], ge_d};
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_PASS:
                begin
                    if (issue_reg)
                    begin
                        if (addr_reg == last_addr)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + ADDR_W'(1);
                        end
                    end
                    if (v1_reg)
                    begin
                        d_reg <= (x_sel >= m_sel) ? x_sel - m_sel : m_sel - x_sel;
                    end
                    if (v2_reg)
                    begin
                        sq_reg <= VAR_W'(d_reg) * VAR_W'(d_reg);
                    end
                    if (v3_reg)
                    begin
                        acc_reg <= acc_reg + SQ_W'(sq_reg);
                    end
                    if (!issue_reg && !v1_reg && !v2_reg && !v3_reg)
                    begin
                        dq_reg    <= acc_reg;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_VDIV;
                    end
                end
                S_VDIV:
                begin
                    if (step_reg == STEP_W'(SQ_W))
                    begin
                        rad_reg   <= dq_reg[VAR_W-1:0];
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        rem_reg  <= ge_d ? diff_d[CNT_W-1:0] : trial_d[CNT_W-1:0];
                        dq_reg   <= {dq_reg[SQ_W-2:0], ge_d};
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_SQRT:
                begin
                    if (step_reg == STEP_W'(TRAIT_BITS))
                    begin
                        spread_reg[t_reg] <= root_reg;
                        if (t_reg == 2'(NUM_TRAITS - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            t_reg     <= t_reg + 2'd1;
                            state_reg <= S_MSTART;
                        end
                    end
                    else
                    begin
                        srem_reg <= ge_s ? cur_s - trial_s : cur_s;
                        root_reg <= {root_reg[TRAIT_BITS-2:0], ge_s};
                        rad_reg  <= {rad_reg[VAR_W-3:0], 2'b00};
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || stats.ready)
                    begin
                        stats.record_count <= cnt_reg;
                        stats.mean_limb    <= mean_reg[0];
                        stats.mean_mass    <= mean_reg[1];
                        stats.mean_scale   <= mean_reg[2];
                        stats.spread_limb  <= spread_reg[0];
                        stats.spread_mass  <= spread_reg[1];
                        stats.spread_scale <= spread_reg[2];
                        stats.overflowed   <= drop_reg;
                        cnt_reg            <= '0;
                        drop_reg           <= 1'b0;
                        for (int i = 0; i < NUM_TRAITS; i++)
                        begin
                            sum_reg[i] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stats.valid = out_valid_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond capacity");
    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!issue_reg && !v1_reg && !v2_reg && !v3_reg))
        else $error("deviation pipeline busy while loading");
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside completion");
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || stats.ready)) |=>
        (cnt_reg == '0 && !drop_reg))
        else $error("set state not cleared after result");
endmodule
`default_nettype wire

FILE: rtl/tmsd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: verif/tmsd_tb_pkg.sv
// Expected-result type used by the checker.
`timescale 1ns / 100ps
package tmsd_tb_pkg;
    import tmsd_pkg::*;

    typedef struct packed {
        logic             [CNT_W-1:0] count;
        trait_t [NUM_TRAITS-1:0]      mean;
        trait_t [NUM_TRAITS-1:0]      spread;
        logic                         ovf;
    } stats_t;
endpackage

FILE: verif/tmsd_checker.sv
// Checker: watches record and result channels, predicts set statistics and compares.
`timescale 1ns / 100ps
module tmsd_checker
    import tmsd_pkg::*;
    import tmsd_tb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic rec_valid,
    input  wire logic rec_ready,
    input  wire logic has_record,
    input  wire trait_t limb,
    input  wire trait_t mass,
    input  wire trait_t scale,
    input  wire logic last_record,
    input  wire logic res_valid,
    input  wire logic res_ready,
    input  wire logic [CNT_W-1:0] record_count,
    input  wire trait_t mean_limb,
    input  wire trait_t mean_mass,
    input  wire trait_t mean_scale,
    input  wire trait_t spread_limb,
    input  wire trait_t spread_mass,
    input  wire trait_t spread_scale,
    input  wire logic overflowed,
    output int errors,
    output int pending
);
    trait_t      set_vals [MAX_RECORDS][NUM_TRAITS];
    int unsigned set_size;
    logic        set_dropped;
    stats_t      stats_due[$];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            longint unsigned c;
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic stats_t close_set();
        stats_t s;
        longint unsigned sum, m, acc, d, sd;
        s = '0;
        s.count = CNT_W'(set_size);
        s.ovf = set_dropped;
        if (set_size != 0)
        begin
            for (int t = 0; t < NUM_TRAITS; t++)
            begin
                sum = 0;
                for (int i = 0; i < set_size; i++)
                    sum += set_vals[i][t];
                m = sum / set_size;
                acc = 0;
                for (int i = 0; i < set_size; i++)
                begin
                    d = (set_vals[i][t] >= m) ? set_vals[i][t] - m : m - set_vals[i][t];
                    acc += d * d;
                end
                sd = isqrt(acc / set_size);
                s.mean[t] = m[15:0];
                s.spread[t] = sd[15:0];
            end
        end
        return s;
    endfunction

    task automatic report(input string what, input longint unsigned got, exp);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, exp);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size <= 0;
            set_dropped <= 1'b0;
            errors <= 0;
            pending <= 0;
            stats_due.delete();
        end
        else
        begin
            if (rec_valid && rec_ready)
            begin
                int unsigned n;
                logic        dr;
                n = set_size;
                dr = set_dropped;
                if (has_record)
                begin
                    if (n < MAX_RECORDS)
                    begin
                        set_vals[n][0] = limb;
                        set_vals[n][1] = mass;
                        set_vals[n][2] = scale;
                        n++;
                    end
                    else
                        dr = 1'b1;
                end
                set_size = n;
                set_dropped = dr;
                if (last_record)
                begin
                    stats_due.insert(stats_due.size(), close_set());
                    set_size = 0;
                    set_dropped = 1'b0;
                end
            end
            if (res_valid && res_ready)
            begin
                if (stats_due.size() == 0)
                    report("unexpected result, count", record_count, 0);
                else
                begin
                    stats_t e;
                    e = stats_due.pop_front();
                    if (record_count !== e.count) report("record_count", record_count, e.count);
                    if (mean_limb !== e.mean[0]) report("mean_limb", mean_limb, e.mean[0]);
                    if (mean_mass !== e.mean[1]) report("mean_mass", mean_mass, e.mean[1]);
                    if (mean_scale !== e.mean[2]) report("mean_scale", mean_scale, e.mean[2]);
                    if (spread_limb !== e.spread[0])
                        report("spread_limb", spread_limb, e.spread[0]);
                    if (spread_mass !== e.spread[1])
                        report("spread_mass", spread_mass, e.spread[1]);
                    if (spread_scale !== e.spread[2])
                        report("spread_scale", spread_scale, e.spread[2]);
                    if (overflowed !== e.ovf) report("overflowed", overflowed, e.ovf);
                end
            end
            pending <= stats_due.size();
        end
    end
endmodule

FILE: verif/tb_trait_mean_and_std_dev.sv
// Testbench top: drives record sets, stalls results and gives the verdict.
`timescale 1ns / 100ps
module tb_trait_mean_and_std_dev;
    import tmsd_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   src_idle;
    int   snk_idle;
    int   sent;

    tmsd_rec_if records ();
    tmsd_res_if stats ();

    trait_mean_and_std_dev DUT (.clk(clk), .rst_n(rst_n), .records(records), .stats(stats));

    tmsd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .rec_valid(records.valid), .rec_ready(records.ready),
        .has_record(records.has_record), .limb(records.limb),
        .mass(records.mass), .scale(records.scale),
        .last_record(records.last_record),
        .res_valid(stats.valid), .res_ready(stats.ready),
        .record_count(stats.record_count), .mean_limb(stats.mean_limb),
        .mean_mass(stats.mean_mass), .mean_scale(stats.mean_scale),
        .spread_limb(stats.spread_limb), .spread_mass(stats.spread_mass),
        .spread_scale(stats.spread_scale), .overflowed(stats.overflowed),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        stats.ready <= ($urandom_range(99) >= snk_idle);

    function automatic trait_t pick_trait();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return trait_t'($urandom_range(255));
            default: return trait_t'($urandom);
        endcase
    endfunction

    task automatic send(input logic hr, input trait_t a, b, c, input logic lr);
        while ($urandom_range(99) < src_idle)
        begin
            records.valid <= 1'b0;
            @(posedge clk);
        end
        records.valid <= 1'b1;
        records.has_record <= hr;
        records.limb <= a;
        records.mass <= b;
        records.scale <= c;
        records.last_record <= lr;
        @(posedge clk);
        while (!records.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_set(input int n, input bit close_empty);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(15) == 0)
                send(1'b0, trait_t'($urandom), trait_t'($urandom), trait_t'($urandom), 1'b0);
            send(1'b1, pick_trait(), pick_trait(), pick_trait(),
                 (i == n - 1) && !close_empty);
        end
        if (close_empty || n == 0)
            send(1'b0, trait_t'($urandom), trait_t'($urandom), trait_t'($urandom), 1'b1);
    endtask

    task automatic drain();
        records.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        records.valid = 1'b0;
        records.has_record = 1'b0;
        records.limb = '0;
        records.mass = '0;
        records.scale = '0;
        records.last_record = 1'b0;
        stats.ready = 1'b0;
        src_idle = 36;
        snk_idle = 52;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(1'b0, '0, '0, '0, 1'b1);
        send(1'b0, '1, '1, '1, 1'b0);
        send(1'b1, '1, '1, '1, 1'b1);
        send(1'b1, '0, '0, '0, 1'b1);
        send(1'b1, '0, '0, '0, 1'b0);
        send(1'b1, '1, '1, '1, 1'b1);
        send(1'b1, '1, '0, 16'h8000, 1'b0);
        send(1'b1, '0, '1, 16'h7FFF, 1'b0);
        send(1'b0, '0, '0, '0, 1'b1);
        drain();

        while (sent < 1450)
        begin
            int n;
            if (sent > 500 && src_idle == 36)
            begin
                src_idle = 52;
                snk_idle = 36;
            end
            else if (sent > 1000 && src_idle == 52)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            case ($urandom_range(9))
                0: n = 0;
                1: n = 1;
                2: n = $urandom_range(250, 262);
                default: n = $urandom_range(2, 20);
            endcase
            if (n > 1450 - sent)
                n = 1450 - sent;
            send_set(n, $urandom_range(3) == 0);
            if ($urandom_range(7) == 0)
                drain();
        end
        drain();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: sim.f
rtl/tmsd_pkg.sv
rtl/tmsd_if.sv
rtl/tmsd_ram.sv
rtl/trait_mean_and_std_dev.sv
verif/tmsd_tb_pkg.sv
verif/tmsd_checker.sv
verif/tb_trait_mean_and_std_dev.sv
